>>> rtl/gamepad_deadzone_hold_counter_core_assert.svh
// assertion macros for the gamepad dead-zone and hold counter core
// expects clk and rst_n in the scope of each use
`ifndef GAMEPAD_DEADZONE_HOLD_COUNTER_CORE_ASSERT_SVH
`define GAMEPAD_DEADZONE_HOLD_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define GDHC_ASSERT_IMP(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("gdhc: same-cycle check failed");

// next-cycle implication
`define GDHC_ASSERT_NXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("gdhc: next-cycle check failed");

`endif

>>> rtl/gdhc_pkg.sv
// shared types, constants and helper functions of the gamepad core
// no dependencies
package gdhc_pkg;

  localparam int NUM_LANE  = 6;   // lx, ly, rx, ry, left trig, right trig
  localparam int MAG_W     = 17;
  localparam int QUO_W     = 16;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = 4;
  localparam int NUM_CNT   = 24;
  localparam int IDX_W     = 5;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_IDX_LSB = 110;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DZ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_SNAP = 2'd2;

  localparam logic [14:0] STICK_DZ_RST  = 15'd5898;
  localparam logic [14:0] TRIG_DZ_RST   = 15'd1638;
  localparam logic [13:0] TRIG_SNAP_RST = 14'd1638;

  localparam logic [MAG_W-1:0] FULL_SCALE = 17'd32768;

  typedef logic [NUM_LANE-1:0][MAG_W-1:0] mag_arr_t;
  typedef logic [NUM_LANE-1:0][QUO_W-1:0] quo_arr_t;

  typedef struct packed {
    logic                clr;
    logic                mapped;
    logic [15:0]         mask;
    logic [NUM_LANE-1:0] neg;
    mag_arr_t            mag;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_st_t;

  // quotient and sign to q1.15, positive side saturates
  function automatic logic [15:0] norm_stick(logic [QUO_W-1:0] q, logic neg);
    logic [16:0] nq;
    nq = 17'd0 - {1'b0, q};
    if (neg) norm_stick = nq[15:0];
    else if (q[15]) norm_stick = 16'h7FFF;
    else norm_stick = q;
  endfunction

  // re-centre a scaled generic trigger and snap near half scale to zero
  function automatic logic [14:0] gen_trig(logic [15:0] n, logic [13:0] snap);
    logic [15:0] s;
    logic [14:0] t;
    logic [14:0] d;
    s = {~n[15], n[14:0]};
    t = s[15:1];
    d = t[14] ? (t - 15'd16384) : (15'd16384 - t);
    gen_trig = (d < {1'b0, snap}) ? 15'd0 : t;
  endfunction

endpackage

>>> rtl/gdhc_div.sv
// six-lane restoring divider, one quotient bit per lane per cycle
// depends on gdhc_pkg
module gdhc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  gdhc_pkg::mag_arr_t num,
  input  gdhc_pkg::mag_arr_t den,
  output logic               done,
  output gdhc_pkg::quo_arr_t quo
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [gdhc_pkg::STEP_W-1:0] step_r, step_nxt;
  gdhc_pkg::mag_arr_t          rem_r, rem_nxt;
  gdhc_pkg::mag_arr_t          den_r, den_nxt;
  gdhc_pkg::quo_arr_t          quo_r, quo_nxt;

  always_comb begin
    logic [gdhc_pkg::MAG_W-1:0] t;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    t        = '0;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      for (int k = 0; k < gdhc_pkg::NUM_LANE; k++) begin
        // remainder never reaches the divisor after the first step, so doubling fits
        t = (step_r == '0) ? rem_r[k] : {rem_r[k][gdhc_pkg::MAG_W-2:0], 1'b0};
        if (t >= den_r[k]) begin
          rem_nxt[k] = t - den_r[k];
          quo_nxt[k] = {quo_r[k][gdhc_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[k] = t;
          quo_nxt[k] = {quo_r[k][gdhc_pkg::QUO_W-2:0], 1'b0};
        end
      end
      step_nxt = step_r + 1'b1;
      if (step_r == gdhc_pkg::STEP_W'(gdhc_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/gdhc_front.sv
// front end: unpacks a poll or clear item and classifies it for the queue
// depends on gdhc_pkg
module gdhc_front (
  input  logic [gdhc_pkg::IN_DATA_W-1:0] tdata,
  input  logic [gdhc_pkg::IN_USER_W-1:0] tuser,
  output gdhc_pkg::entry_t               entry
);

  logic [13:0]  buttons;
  logic [3:0]   hat;
  logic [13:0]  pressed;
  logic [15:0]  raw [gdhc_pkg::NUM_LANE];

  assign buttons = tdata[13:0];
  assign hat     = tdata[17:14];

  always_comb begin
    for (int k = 0; k < gdhc_pkg::NUM_LANE; k++) begin
      raw[k] = tdata[18 + 16*k +: 16];
    end
  end

  // hat folds into the d-pad only for the generic layout
  assign pressed = buttons | {10'd0, (tuser[1] ? 4'd0 : hat)};

  always_comb begin
    entry.clr    = tuser[0];
    entry.mapped = tuser[1];
    entry.mask   = {pressed[13:10], 2'b00, pressed[9:0]};
    for (int k = 0; k < gdhc_pkg::NUM_LANE; k++) begin
      entry.neg[k] = raw[k][15];
      entry.mag[k] = raw[k][15] ? (17'd0 - {raw[k][15], raw[k]}) : {1'b0, raw[k]};
    end
  end

endmodule

>>> rtl/gdhc_fifo.sv
// two-entry queue between the front end and the back end
// depends on gdhc_pkg
module gdhc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gdhc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output gdhc_pkg::entry_t pop_data,
  output logic             empty
);

  gdhc_pkg::entry_t              mem_r [gdhc_pkg::QDEPTH];
  logic [gdhc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [gdhc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [gdhc_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full     = (cnt_r == gdhc_pkg::QCNT_W'(gdhc_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/gdhc_back.sv
// back end: dead-zone division, trigger levels, hold counters and result register
// depends on gdhc_pkg, gdhc_div and the assertion macro header
`include "gamepad_deadzone_hold_counter_core_assert.svh"

module gdhc_back #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  gdhc_pkg::entry_t                q_data,
  output logic                            q_pop,
  input  logic [14:0]                     stick_dz,
  input  logic [14:0]                     trig_dz,
  input  logic [13:0]                     trig_snap,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gdhc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam logic signed [COUNTER_WIDTH-1:0] CMAX = {1'b0, {(COUNTER_WIDTH-1){1'b1}}};
  localparam logic signed [COUNTER_WIDTH-1:0] CMIN = {1'b1, {(COUNTER_WIDTH-1){1'b0}}};
  localparam logic signed [COUNTER_WIDTH-1:0] CONE = COUNTER_WIDTH'(1);

  gdhc_pkg::back_st_t st_r, st_nxt;
  gdhc_pkg::entry_t   ent_r, ent_nxt;
  logic [15:0]        nlx_r, nly_r, nrx_r, nry_r;
  logic [15:0]        nlx_nxt, nly_nxt, nrx_nxt, nry_nxt;
  logic [14:0]        nlt_r, nrt_r, nlt_nxt, nrt_nxt;
  logic [gdhc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic signed [COUNTER_WIDTH-1:0] cnt_r [gdhc_pkg::NUM_CNT];
  logic signed [COUNTER_WIDTH-1:0] cnt_nxt [gdhc_pkg::NUM_CNT];
  logic                              out_valid_r, out_valid_nxt;
  logic [gdhc_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                div_start, div_done;
  gdhc_pkg::mag_arr_t  div_num, div_den;
  gdhc_pkg::quo_arr_t  div_quo;

  logic [23:0]                     act;
  logic signed [COUNTER_WIDTH-1:0] cur, upd;
  logic                            slot_free;

  gdhc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // dividend is the excess over the dead zone, zero inside it
  always_comb begin
    logic [14:0] dz;
    for (int k = 0; k < gdhc_pkg::NUM_LANE; k++) begin
      dz = (k < 4) ? stick_dz : trig_dz;
      div_num[k] = (q_data.mag[k] > {2'b00, dz}) ? (q_data.mag[k] - {2'b00, dz}) : '0;
      div_den[k] = gdhc_pkg::FULL_SCALE - {2'b00, dz};
    end
  end

  // pressed state of each counter, in counter order
  always_comb begin
    act[0]  = !nly_r[15] && (nly_r != '0);
    act[1]  = nly_r[15];
    act[2]  = nlx_r[15];
    act[3]  = !nlx_r[15] && (nlx_r != '0);
    act[4]  = !nry_r[15] && (nry_r != '0);
    act[5]  = nry_r[15];
    act[6]  = nrx_r[15];
    act[7]  = !nrx_r[15] && (nrx_r != '0);
    act[15:8] = ent_r.mask[7:0];
    act[16] = ent_r.mask[8];
    act[17] = (nlt_r != '0);
    act[18] = ent_r.mask[9];
    act[19] = (nrt_r != '0);
    act[23:20] = ent_r.mask[15:12];
  end

  assign cur = cnt_r[idx_r];

  always_comb begin
    upd = cur;
    if (act[idx_r]) begin
      if (cur[COUNTER_WIDTH-1] || (cur == '0)) upd = CONE;
      else if (cur != CMAX) upd = cur + CONE;
    end else begin
      if (!cur[COUNTER_WIDTH-1] && (cur != '0)) upd = '0;
      else if (cur != CMIN) upd = cur - CONE;
    end
  end

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    logic [15:0] nlt_s, nrt_s;
    st_nxt        = st_r;
    ent_nxt       = ent_r;
    nlx_nxt       = nlx_r;
    nly_nxt       = nly_r;
    nrx_nxt       = nrx_r;
    nry_nxt       = nry_r;
    nlt_nxt       = nlt_r;
    nrt_nxt       = nrt_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    nlt_s         = gdhc_pkg::norm_stick(div_quo[4], ent_r.neg[4]);
    nrt_s         = gdhc_pkg::norm_stick(div_quo[5], ent_r.neg[5]);
    case (st_r)
      gdhc_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.clr) begin
            for (int k = 0; k < gdhc_pkg::NUM_CNT; k++) cnt_nxt[k] = '0;
          end else begin
            ent_nxt   = q_data;
            div_start = 1'b1;
            st_nxt    = gdhc_pkg::ST_DIV;
          end
        end
      end
      gdhc_pkg::ST_DIV: begin
        if (div_done) begin
          nlx_nxt = gdhc_pkg::norm_stick(div_quo[0], ent_r.neg[0]);
          nly_nxt = gdhc_pkg::norm_stick(div_quo[1], ent_r.neg[1]);
          nrx_nxt = gdhc_pkg::norm_stick(div_quo[2], ent_r.neg[2]);
          nry_nxt = gdhc_pkg::norm_stick(div_quo[3], ent_r.neg[3]);
          if (ent_r.mapped) begin
            nlt_nxt = ent_r.neg[4] ? 15'd0 : ent_r.mag[4][14:0];
            nrt_nxt = ent_r.neg[5] ? 15'd0 : ent_r.mag[5][14:0];
          end else begin
            nlt_nxt = gdhc_pkg::gen_trig(nlt_s, trig_snap);
            nrt_nxt = gdhc_pkg::gen_trig(nrt_s, trig_snap);
          end
          idx_nxt = '0;
          st_nxt  = gdhc_pkg::ST_EMIT;
        end
      end
      gdhc_pkg::ST_EMIT: begin
        if (slot_free) begin
          cnt_nxt[idx_r] = upd;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {5'd0, 32'(upd), idx_r, nrt_r, nlt_r,
                            nry_r, nrx_r, nly_r, nlx_r, ent_r.mask};
          out_last_nxt   = (idx_r == gdhc_pkg::IDX_W'(gdhc_pkg::NUM_CNT - 1));
          if (idx_r == gdhc_pkg::IDX_W'(gdhc_pkg::NUM_CNT - 1)) begin
            st_nxt = gdhc_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: st_nxt = gdhc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= gdhc_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < gdhc_pkg::NUM_CNT; k++) cnt_r[k] <= '0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < gdhc_pkg::NUM_CNT; k++) cnt_r[k] <= cnt_nxt[k];
    end
    ent_r      <= ent_nxt;
    nlx_r      <= nlx_nxt;
    nly_r      <= nly_nxt;
    nrx_r      <= nrx_nxt;
    nry_r      <= nry_nxt;
    nlt_r      <= nlt_nxt;
    nrt_r      <= nrt_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `GDHC_ASSERT_IMP(a_last_is_final_idx, out_valid_r && out_last_r,
    out_data_r[gdhc_pkg::OUT_IDX_LSB +: gdhc_pkg::IDX_W] == gdhc_pkg::IDX_W'(gdhc_pkg::NUM_CNT - 1))
  `GDHC_ASSERT_NXT(a_clear_zeroes, (st_r == gdhc_pkg::ST_IDLE) && q_valid && q_data.clr,
    (cnt_r[0] == '0) && (cnt_r[gdhc_pkg::NUM_CNT-1] == '0))
  `GDHC_ASSERT_IMP(a_div_done_in_div, div_done, st_r == gdhc_pkg::ST_DIV)
  `GDHC_ASSERT_IMP(a_emit_idx_range, st_r == gdhc_pkg::ST_EMIT,
    idx_r < gdhc_pkg::IDX_W'(gdhc_pkg::NUM_CNT))

endmodule

>>> rtl/gamepad_deadzone_hold_counter_core.sv
// top level of the gamepad dead-zone and hold counter core
// depends on gdhc_pkg, gdhc_front, gdhc_fifo, gdhc_back (with gdhc_div)
//
// channel  direction  ports                        item
// in_      slave      tvalid tready tdata tuser    poll sample or counter clear
// out_     master     tvalid tready tdata tlast    one hold counter result
// cfg_     write      we index wdata               dead zone and snap registers
//
// a poll produces 24 results; it leaves the queue in the idle state, passes through the
// six-lane divider, forms its levels when the divider is done, then emits its 24 results,
// waiting while out_ is stalled; a clear zeroes the counters and gives no result
// reset (rst_n low, synchronous) zeroes all counters and restores register defaults
// a two-entry queue holds up to two waiting items while the back end works or out_
// stalls; in_tready drops only while both entries are occupied
module gamepad_deadzone_hold_counter_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // buttons[13:0], hat[17:14], left_x[33:18], left_y[49:34], right_x[65:50],
  // right_y[81:66], left_trig[97:82], right_trig[113:98], zero fill
  input  logic [gdhc_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[0], mapped[1]
  input  logic [gdhc_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // key_mask[15:0], norm_left_x[31:16], norm_left_y[47:32], norm_right_x[63:48],
  // norm_right_y[79:64], norm_left_trig[94:80], norm_right_trig[109:95],
  // counter_index[114:110], counter_value[146:115], zero fill
  output logic [gdhc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [gdhc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gdhc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [14:0] stick_dz_r, stick_dz_nxt;
  logic [14:0] trig_dz_r, trig_dz_nxt;
  logic [13:0] trig_snap_r, trig_snap_nxt;

  gdhc_pkg::entry_t front_entry, q_data;
  logic             q_full, q_empty, q_pop;

  always_comb begin
    stick_dz_nxt  = stick_dz_r;
    trig_dz_nxt   = trig_dz_r;
    trig_snap_nxt = trig_snap_r;
    if (cfg_we) begin
      case (cfg_index)
        gdhc_pkg::CFG_STICK_DZ:  stick_dz_nxt  = cfg_wdata;
        gdhc_pkg::CFG_TRIG_DZ:   trig_dz_nxt   = cfg_wdata;
        gdhc_pkg::CFG_TRIG_SNAP: trig_snap_nxt = cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_dz_r  <= gdhc_pkg::STICK_DZ_RST;
      trig_dz_r   <= gdhc_pkg::TRIG_DZ_RST;
      trig_snap_r <= gdhc_pkg::TRIG_SNAP_RST;
    end else begin
      stick_dz_r  <= stick_dz_nxt;
      trig_dz_r   <= trig_dz_nxt;
      trig_snap_r <= trig_snap_nxt;
    end
  end

  assign in_tready = !q_full;

  gdhc_front u_front (
    .tdata (in_tdata),
    .tuser (in_tuser),
    .entry (front_entry)
  );

  gdhc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  gdhc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .stick_dz   (stick_dz_r),
    .trig_dz    (trig_dz_r),
    .trig_snap  (trig_snap_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for gamepad_deadzone_hold_counter_core: a queue-fed stream driver, a result monitor
// and a self-contained predictor of the dead-zone scaling, trigger levels and hold counters
// depends on gdhc_pkg and the core rtl
module tb;

  localparam int CNT_W         = 32;
  localparam int HOLD_COUNTERS = 24;
  localparam int SETTLE_CYCLES = 64;
  localparam int STUCK_LIMIT   = 4000;
  localparam int PHASES        = 6;
  localparam int RANDOM_POLLS  = 51;

  localparam logic [14:0] RST_STICK_DZ  = 15'd5898;
  localparam logic [14:0] RST_TRIG_DZ   = 15'd1638;
  localparam logic [13:0] RST_TRIG_SNAP = 14'd1638;

  // index with no register behind it
  localparam logic [gdhc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic               clr;
    logic               mapped;
    logic [13:0]        buttons;
    logic [3:0]         hat;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] lt;
    logic signed [15:0] rt;
  } sample_t;

  // mirrors {out_tlast, out_tdata}, highest bits first
  typedef struct packed {
    logic        last;
    logic [4:0]  fill;
    logic [31:0] value;
    logic [4:0]  idx;
    logic [14:0] rtrig;
    logic [14:0] ltrig;
    logic [15:0] nry;
    logic [15:0] nrx;
    logic [15:0] nly;
    logic [15:0] nlx;
    logic [15:0] key_mask;
  } hold_report_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gdhc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [gdhc_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [gdhc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            cfg_we = 1'b0;
  logic [gdhc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gdhc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sample_t      sample_q[$];
  hold_report_t hold_reports_q[$];
  sample_t      cur_sample;
  longint       hold_cnt[HOLD_COUNTERS];
  logic [14:0]  stick_dz = RST_STICK_DZ;
  logic [14:0]  trig_dz = RST_TRIG_DZ;
  logic [13:0]  trig_snap = RST_TRIG_SNAP;
  bit           quiet = 1'b0;
  int           in_idle = 0;
  int           out_stall = 0;
  int           err_count = 0;
  int           result_no = 0;
  int           stuck = 0;

  gamepad_deadzone_hold_counter_core #(
    .COUNTER_WIDTH(CNT_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [15:0] scale_axis(input logic signed [15:0] raw,
                                                    input logic [14:0] dz);
    int m;
    int d;
    int q;
    d = int'(dz);
    m = (raw < 0) ? -int'(raw) : int'(raw);
    if (m <= d) return 16'sd0;
    q = ((m - d) * 32768) / (32768 - d);
    if (q > 32768) q = 32768;
    if (raw < 0) return 16'(-q);
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic logic [14:0] level_mapped(input logic signed [15:0] raw);
    return (raw < 0) ? 15'd0 : raw[14:0];
  endfunction

  // re-centred generic trigger, snapped to zero near half scale
  function automatic logic [14:0] level_generic(input logic signed [15:0] raw);
    int n;
    int t;
    int d;
    n = int'(scale_axis(raw, trig_dz));
    t = (n + 32768) / 2;
    d = t - 16384;
    if (d < 0) d = -d;
    if (d < int'(trig_snap)) t = 0;
    return t[14:0];
  endfunction

  function automatic longint step_count(input longint c, input logic held);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CNT_W - 1)) - 1;
    lo = -hi - 1;
    if (held) begin
      if (c <= 0) return 1;
      return (c < hi) ? c + 1 : c;
    end
    if (c >= 1) return 0;
    return (c > lo) ? c - 1 : c;
  endfunction

  function automatic void predict_poll_reports(input sample_t s);
    logic [13:0]        held;
    logic [15:0]        mask;
    logic signed [15:0] nlx, nly, nrx, nry;
    logic [14:0]        lt, rt;
    logic [23:0]        act;
    hold_report_t       r;
    int                 i;
    if (s.clr) begin
      foreach (hold_cnt[j]) hold_cnt[j] = 0;
      return;
    end
    held = s.buttons;
    if (!s.mapped) held[3:0] = held[3:0] | s.hat;
    mask = {held[13:10], 2'b00, held[9:0]};
    nlx = scale_axis(s.lx, stick_dz);
    nly = scale_axis(s.ly, stick_dz);
    nrx = scale_axis(s.rx, stick_dz);
    nry = scale_axis(s.ry, stick_dz);
    if (s.mapped) begin
      lt = level_mapped(s.lt);
      rt = level_mapped(s.rt);
    end else begin
      lt = level_generic(s.lt);
      rt = level_generic(s.rt);
    end
    act[0] = nly > 0;
    act[1] = nly < 0;
    act[2] = nlx < 0;
    act[3] = nlx > 0;
    act[4] = nry > 0;
    act[5] = nry < 0;
    act[6] = nrx < 0;
    act[7] = nrx > 0;
    act[15:8] = held[7:0];
    act[16] = held[8];
    act[17] = lt != 0;
    act[18] = held[9];
    act[19] = rt != 0;
    act[23:20] = held[13:10];
    for (i = 0; i < HOLD_COUNTERS; i++) begin
      hold_cnt[i] = step_count(hold_cnt[i], act[i]);
      r.last = (i == HOLD_COUNTERS - 1);
      r.fill = '0;
      r.value = hold_cnt[i][31:0];
      r.idx = i[4:0];
      r.rtrig = rt;
      r.ltrig = lt;
      r.nry = nry;
      r.nrx = nrx;
      r.nly = nly;
      r.nlx = nlx;
      r.key_mask = mask;
      hold_reports_q.insert(hold_reports_q.size(), r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", result_no, name, got, want));
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic sample_t mk(input bit clr, input bit mapped, input int buttons,
                                 input int hat, input int lx, input int ly, input int rx,
                                 input int ry, input int lt, input int rt);
    sample_t s;
    s.clr = clr;
    s.mapped = mapped;
    s.buttons = buttons[13:0];
    s.hat = hat[3:0];
    s.lx = lx[15:0];
    s.ly = ly[15:0];
    s.rx = rx[15:0];
    s.ry = ry[15:0];
    s.lt = lt[15:0];
    s.rt = rt[15:0];
    return s;
  endfunction

  function automatic void queue_sample(input sample_t s);
    sample_q.insert(sample_q.size(), s);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // biased towards full scale and the dead-zone edges
  function automatic logic signed [15:0] pick_axis(input int dz);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'(clamp16(dz));
      4: return 16'(clamp16(-dz));
      5: return 16'(clamp16(dz + 1));
      6: return 16'(clamp16(-dz - 1));
      default: begin
        v = 16'($urandom_range(0, 65535));
        return v;
      end
    endcase
  endfunction

  function automatic logic signed [15:0] pick_trig(input bit mapped);
    logic [15:0] v;
    int          edge2;
    if (mapped) return pick_axis(int'($urandom_range(0, 3)) - 1);
    // with no trigger dead zone the snap edge sits near twice the snap value
    edge2 = 2 * int'(trig_snap) + int'($urandom_range(0, 2)) - 1;
    case ($urandom_range(0, 5))
      0, 1: return pick_axis(int'(trig_dz));
      2: return 16'(clamp16(edge2));
      3: return 16'(clamp16(-edge2));
      default: begin
        v = 16'($urandom_range(0, 65535));
        return v;
      end
    endcase
  endfunction

  function automatic sample_t next_poll(input sample_t prev);
    sample_t s;
    if ($urandom_range(0, 24) == 0) begin
      // clear, the other fields are junk
      s = mk(1, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
      return s;
    end
    if (prev.clr || $urandom_range(0, 9) < 3) begin
      s.mapped = 1'($urandom_range(0, 1));
      s.buttons = 14'($urandom_range(0, 16383));
      s.hat = 4'($urandom_range(0, 15));
      s.lx = pick_axis(int'(stick_dz));
      s.ly = pick_axis(int'(stick_dz));
      s.rx = pick_axis(int'(stick_dz));
      s.ry = pick_axis(int'(stick_dz));
      s.lt = pick_trig(s.mapped);
      s.rt = pick_trig(s.mapped);
    end else begin
      // held run: a few bits change per poll so counters build up
      s = prev;
      if ($urandom_range(0, 11) == 0) s.mapped = ~s.mapped;
      s.buttons ^= 14'($urandom & $urandom & $urandom);
      s.hat ^= 4'($urandom & $urandom & $urandom);
      if ($urandom_range(0, 2) == 0) s.lx = pick_axis(int'(stick_dz));
      if ($urandom_range(0, 2) == 0) s.ly = pick_axis(int'(stick_dz));
      if ($urandom_range(0, 2) == 0) s.rx = pick_axis(int'(stick_dz));
      if ($urandom_range(0, 2) == 0) s.ry = pick_axis(int'(stick_dz));
      if ($urandom_range(0, 2) == 0) s.lt = pick_trig(s.mapped);
      if ($urandom_range(0, 2) == 0) s.rt = pick_trig(s.mapped);
    end
    s.clr = 1'b0;
    return s;
  endfunction

  task automatic write_reg(input logic [gdhc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gdhc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gdhc_pkg::CFG_STICK_DZ:  stick_dz = val[14:0];
      gdhc_pkg::CFG_TRIG_DZ:   trig_dz = val[14:0];
      gdhc_pkg::CFG_TRIG_SNAP: trig_snap = val[13:0];
      default: ;
    endcase
  endtask

  // everything sent and answered, then room for a trailing clear to finish
  task automatic settle();
    while (sample_q.size() != 0 || in_tvalid || hold_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_poll_reports(cur_sample);
      if (!in_tvalid || in_tready) begin
        if (in_idle > 0) begin
          in_idle--;
          in_tvalid <= 1'b0;
        end else if (!quiet && sample_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          in_idle = $urandom_range(0, 13);
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_sample = sample_q.pop_front();
          in_tdata <= {6'd0, cur_sample.rt, cur_sample.lt, cur_sample.ry, cur_sample.rx,
                       cur_sample.ly, cur_sample.lx, cur_sample.hat, cur_sample.buttons};
          in_tuser <= {cur_sample.mapped, cur_sample.clr};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    hold_report_t got;
    hold_report_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (hold_reports_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected, index %0d",
                                    result_no, got.idx));
        end else begin
          want = hold_reports_q.pop_front();
          cmp_field("key_mask", 32'(got.key_mask), 32'(want.key_mask));
          cmp_field("norm_left_x", 32'(got.nlx), 32'(want.nlx));
          cmp_field("norm_left_y", 32'(got.nly), 32'(want.nly));
          cmp_field("norm_right_x", 32'(got.nrx), 32'(want.nrx));
          cmp_field("norm_right_y", 32'(got.nry), 32'(want.nry));
          cmp_field("norm_left_trig", 32'(got.ltrig), 32'(want.ltrig));
          cmp_field("norm_right_trig", 32'(got.rtrig), 32'(want.rtrig));
          cmp_field("counter_index", 32'(got.idx), 32'(want.idx));
          cmp_field("counter_value", got.value, want.value);
          cmp_field("zero fill", 32'(got.fill), 32'(want.fill));
          cmp_field("tlast", 32'(got.last), 32'(want.last));
        end
        result_no++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int      ph;
    int      k;
    sample_t prev;
    prev = mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    foreach (hold_cnt[j]) hold_cnt[j] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) settle();
      case (ph)
        0: begin
          // register defaults, extremes, hat folding, snapping and clears
          queue_sample(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
          queue_sample(mk(0, 1, 'h3FFF, 'hF, 32767, 32767, -32768, -32768,
                          32767, -32768));
          queue_sample(mk(0, 1, 'h3FFF, 'hF, 32767, 32767, -32768, -32768,
                          32767, -32768));
          queue_sample(mk(0, 0, 0, 'hF, 5898, -5898, 5899, -5899, 0, -32768));
          queue_sample(mk(0, 0, 'h2AAA, 'h5, -32768, 32767, 0, 1, 32767, 1638));
          queue_sample(mk(1, 1, 'h3FFF, 'hF, -1, -1, -1, -1, -1, -1));
          queue_sample(mk(0, 1, 'h1555, 'hA, -1, 1, -5899, 5899, 1, -1));
          queue_sample(mk(0, 0, 'h3FFF, 0, 100, -100, 0, 0, 1639, -1639));
          queue_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 32767, 4000));
          queue_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 32767, 4000));
          queue_sample(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          queue_sample(mk(0, 1, 'h3C00, 0, 20000, -20000, -20000, 20000, 16384, 0));
          queue_sample(mk(0, 0, 'h3FFF, 'hF, 32767, -32768, 32767, -32768,
                          -32768, 32767));
        end
        1: begin
          // no dead zones and no snap: a centred generic trigger reads as pressed
          write_reg(gdhc_pkg::CFG_STICK_DZ, 15'd0);
          write_reg(gdhc_pkg::CFG_TRIG_DZ, 15'd0);
          write_reg(gdhc_pkg::CFG_TRIG_SNAP, 15'd0);
          queue_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          queue_sample(mk(0, 0, 0, 0, 1, -1, 32767, -32768, 0, 0));
        end
        2: begin
          // widest dead zones; bit 14 of the snap write is dropped
          write_reg(gdhc_pkg::CFG_STICK_DZ, 15'h7FFF);
          write_reg(gdhc_pkg::CFG_TRIG_DZ, 15'h7FFF);
          write_reg(gdhc_pkg::CFG_TRIG_SNAP, 15'h7FFF);
          write_reg(CFG_UNUSED, 15'($urandom));
          queue_sample(mk(0, 0, 0, 0, -32768, 32767, -32767, -32768, -32768, 32767));
        end
        default: begin
          write_reg(gdhc_pkg::CFG_STICK_DZ, 15'($urandom));
          write_reg(gdhc_pkg::CFG_TRIG_DZ, 15'($urandom));
          write_reg(gdhc_pkg::CFG_TRIG_SNAP, 15'($urandom));
          if (ph == PHASES - 1) quiet = 1'b1;
        end
      endcase
      for (k = 0; k < RANDOM_POLLS; k++) begin
        prev = next_poll(prev);
        queue_sample(prev);
      end
    end
    settle();
    if (err_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
